// File: rtl/mhp_pkg.sv
// Shared types and constants for the 802.11 MAC header parser.
`default_nettype none

package mhp_pkg;

  // Header bytes kept per frame; covers the longest decoded header.
  localparam int unsigned HdrDepth  = 34;
  localparam int unsigned CountW    = $clog2(HdrDepth);
  localparam int unsigned LenW      = CountW + 1;
  localparam logic [CountW-1:0] CountMax = '1;

  // Length thresholds.
  localparam logic [LenW-1:0] MinLenAny   = LenW'(10);
  localparam logic [LenW-1:0] MinLen3Addr = LenW'(24);
  localparam logic [LenW-1:0] MinLen4Addr = LenW'(30);

  localparam logic [15:0] VersionMask = 16'h0003;
  localparam logic [15:0] OrderMask   = 16'h8000;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StBadVersion = 2'd1,
    StShort      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KindMgmt = 2'd0,
    KindCtrl = 2'd1,
    KindData = 2'd2,
    KindExt  = 2'd3
  } kind_e;

  // Control subtypes that carry a receiver address.
  localparam logic [3:0] SubRts = 4'h0B;
  localparam logic [3:0] SubCts = 4'h0C;
  localparam logic [3:0] SubAck = 4'h0D;

  typedef logic [7:0]  byte_t;
  typedef logic [47:0] mac_addr_t;

  // Result transaction; first member lands in the top bits, status in the lowest.
  typedef struct packed {
    logic [15:0] ht_control;
    logic [15:0] qos_control;
    logic [15:0] sequence_control;
    mac_addr_t   address_four;
    mac_addr_t   address_three;
    mac_addr_t   address_two;
    mac_addr_t   address_one;
    logic [3:0]  frame_subtype;
    logic [1:0]  frame_kind;
    logic [15:0] dur_id;
    logic [15:0] frame_ctrl;
    logic [1:0]  parse_status;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

// File: rtl/mac_header_parser_core.sv
// 802.11 MAC header parser: byte stream in, one decoded header transaction per frame out.
`default_nettype none

// Takes one frame byte per cycle on the slave stream, tlast on the final byte.
// The first 34 bytes go into a header register file indexed by the byte count;
// on the last byte the frame length is latched and, in the next cycle, the
// decode logic between the header registers and the result register builds
// the header transaction, which the result register then holds for the master
// stream. The block keeps taking one byte per cycle, also back to back across
// frames. s_axis_tready drops only while a decoded frame waits for the result
// register to free up, since the next frame's bytes would overwrite the header
// registers.
module mac_header_parser_core import mhp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  wire logic               s_axis_tlast,   // last_byte
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [1:0] parse_status, [17:2] frame_ctrl, [33:18] dur_id,
  // [35:34] frame_kind, [39:36] frame_subtype, [87:40] address_one,
  // [135:88] address_two, [183:136] address_three, [231:184] address_four,
  // [247:232] sequence_control, [263:248] qos_control, [279:264] ht_control
  output      logic [ResultW-1:0] m_axis_tdata
);

  byte_t               hdr_q [HdrDepth];
  logic [CountW-1:0]   count_q, count_d;
  logic [LenW-1:0]     len_q;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  result_t             result_q, result_d;

  logic in_acc, advance;

  assign advance       = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Byte count and handoff control
  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
    if (in_acc) begin
      if (s_axis_tlast) begin
        count_d = '0;
        pend_d  = 1'b1;
      end else if (count_q != CountMax) begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header capture; bytes past the header depth are only counted
  always_ff @(posedge clk_i) begin
    if (in_acc && (LenW'(count_q) < LenW'(HdrDepth))) begin
      hdr_q[count_q] <= s_axis_tdata;
    end
    if (in_acc && s_axis_tlast) begin
      len_q <= LenW'(count_q) + LenW'(1);
    end
  end

  // Header decode
  always_comb begin
    logic [15:0]     fc;
    logic [1:0]      kind;
    logic [3:0]      sub;
    logic            four;
    logic            ok;
    logic            qos_ok;
    logic            ht_ok;
    logic [LenW-1:0] qos_need;
    logic [LenW-1:0] ht_need;
    logic [15:0]     seq_w;
    logic [15:0]     qos_w;
    logic [15:0]     ht_w;
    mac_addr_t       a1, a2, a3, a4;

    fc   = {hdr_q[1], hdr_q[0]};
    kind = fc[3:2];
    sub  = fc[7:4];
    four = fc[8] && fc[9];
    a1   = {hdr_q[4],  hdr_q[5],  hdr_q[6],  hdr_q[7],  hdr_q[8],  hdr_q[9]};
    a2   = {hdr_q[10], hdr_q[11], hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
    a3   = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19], hdr_q[20], hdr_q[21]};
    a4   = {hdr_q[22], hdr_q[23], hdr_q[24], hdr_q[25], hdr_q[26], hdr_q[27]};

    // Data frame trailer positions shift by one address in the 4-address case
    seq_w    = four ? {hdr_q[29], hdr_q[28]} : {hdr_q[23], hdr_q[22]};
    qos_w    = four ? {hdr_q[31], hdr_q[30]} : {hdr_q[25], hdr_q[24]};
    qos_need = four ? LenW'(32) : LenW'(26);
    qos_ok   = sub[3] && (len_q >= qos_need);
    if (four) begin
      ht_w    = qos_ok ? {hdr_q[33], hdr_q[32]} : {hdr_q[31], hdr_q[30]};
      ht_need = qos_ok ? LenW'(34) : LenW'(32);
    end else begin
      ht_w    = qos_ok ? {hdr_q[27], hdr_q[26]} : {hdr_q[25], hdr_q[24]};
      ht_need = qos_ok ? LenW'(28) : LenW'(26);
    end
    ht_ok = ((fc & OrderMask) != 16'h0000) && (len_q >= ht_need);

    result_d = '0;
    ok       = 1'b0;
    if (len_q < MinLenAny) begin
      result_d.parse_status = StShort;
    end else if ((fc & VersionMask) != 16'h0000) begin
      result_d.parse_status = StBadVersion;
    end else begin
      ok = 1'b1;
      case (kind)
        KindData: begin
          if (len_q < (four ? MinLen4Addr : MinLen3Addr)) begin
            ok                    = 1'b0;
            result_d.parse_status = StShort;
          end else begin
            result_d.address_one      = a1;
            result_d.address_two      = a2;
            result_d.address_three    = a3;
            result_d.address_four     = four ? a4 : '0;
            result_d.sequence_control = seq_w;
            result_d.qos_control      = qos_ok ? qos_w : '0;
            result_d.ht_control       = ht_ok ? ht_w : '0;
          end
        end
        KindMgmt: begin
          if (len_q < MinLen3Addr) begin
            ok                    = 1'b0;
            result_d.parse_status = StShort;
          end else begin
            result_d.address_one      = a1;
            result_d.address_two      = a2;
            result_d.address_three    = a3;
            result_d.sequence_control = {hdr_q[23], hdr_q[22]};
          end
        end
        KindCtrl: begin
          if (sub inside {SubRts, SubCts, SubAck}) begin
            result_d.address_one = a1;
          end
        end
        default: ;  // extension frames carry no decoded addresses
      endcase
      if (ok) begin
        result_d.parse_status  = StOk;
        result_d.frame_ctrl    = fc;
        result_d.dur_id        = {hdr_q[3], hdr_q[2]};
        result_d.frame_kind    = kind;
        result_d.frame_subtype = sub;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the 802.11 MAC header parser core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mhp_pkg::*;

  typedef struct {
    byte_t data;
    logic  last;
  } rx_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = 8'h00;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ResultW-1:0] m_axis_tdata;

  mac_header_parser_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Pending frame bytes and decoded headers still owed by the block
  rx_byte_t    pending_bytes[$];
  result_t     expected_headers[$];
  int unsigned frames_queued = 0;
  int unsigned bytes_queued = 0;
  int unsigned headers_seen = 0;
  int unsigned error_count = 0;
  int unsigned status_tally[3] = '{0, 0, 0};
  bit          idle_on = 1'b1;
  bit          byte_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;

  // Header shadow of the frame in flight
  byte_t       hdr_q[HdrDepth];
  int unsigned frame_len_q = 0;

  function automatic logic [15:0] word_at(int unsigned pos);
    return {hdr_q[pos+1], hdr_q[pos]};
  endfunction

  function automatic mac_addr_t addr_at(int unsigned pos);
    return {hdr_q[pos], hdr_q[pos+1], hdr_q[pos+2], hdr_q[pos+3], hdr_q[pos+4], hdr_q[pos+5]};
  endfunction

  function automatic result_t decode_header(int unsigned len);
    result_t     r;
    logic [15:0] fc;
    kind_e       kind;
    logic [3:0]  sub;
    logic        four;
    int unsigned off;
    r = '0;
    if (len < MinLenAny) begin
      r.parse_status = StShort;
      return r;
    end
    fc = word_at(0);
    if ((fc & VersionMask) != 16'h0000) begin
      r.parse_status = StBadVersion;
      return r;
    end
    kind = kind_e'(fc[3:2]);
    sub  = fc[7:4];
    case (kind)
      KindData: begin
        four = fc[8] & fc[9];
        if (len < (four ? MinLen4Addr : MinLen3Addr)) begin
          r.parse_status = StShort;
          return r;
        end
        r.address_one   = addr_at(4);
        r.address_two   = addr_at(10);
        r.address_three = addr_at(16);
        off = 22;
        if (four) begin
          r.address_four = addr_at(22);
          off = 28;
        end
        r.sequence_control = word_at(off);
        off += 2;
        // QoS subtypes carry QoS control, if the frame is long enough
        if (sub[3] && len >= off + 2) begin
          r.qos_control = word_at(off);
          off += 2;
        end
        if ((fc & OrderMask) != 16'h0000 && len >= off + 2) begin
          r.ht_control = word_at(off);
        end
      end
      KindMgmt: begin
        if (len < MinLen3Addr) begin
          r.parse_status = StShort;
          return r;
        end
        r.address_one      = addr_at(4);
        r.address_two      = addr_at(10);
        r.address_three    = addr_at(16);
        r.sequence_control = word_at(22);
      end
      KindCtrl: begin
        if (sub == SubRts || sub == SubCts || sub == SubAck) begin
          r.address_one = addr_at(4);
        end
      end
      default: begin
      end
    endcase
    r.parse_status  = StOk;
    r.frame_ctrl    = fc;
    r.dur_id        = word_at(2);
    r.frame_kind    = kind;
    r.frame_subtype = sub;
    return r;
  endfunction

  task automatic absorb_byte(byte_t d, logic last);
    result_t r;
    if (frame_len_q < HdrDepth) hdr_q[frame_len_q] = d;
    if (!last) begin
      if (frame_len_q < int'(CountMax)) frame_len_q++;
    end else begin
      r = decode_header(frame_len_q + 1);
      expected_headers.push_back(r);
      status_tally[r.parse_status]++;
      frame_len_q = 0;
    end
  endtask

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10) begin
        $display("header %0d, %s: expected %h, got %h", headers_seen, name, want, got);
      end
    end
  endtask

  // Monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    byte_taken = rst_ni && s_axis_tvalid && s_axis_tready === 1'b1;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_headers.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("header %0d arrived with none pending", headers_seen);
      end else begin
        want = expected_headers.pop_front();
        check_field("parse_status", want.parse_status, got.parse_status);
        check_field("frame_ctrl", want.frame_ctrl, got.frame_ctrl);
        check_field("dur_id", want.dur_id, got.dur_id);
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("frame_subtype", want.frame_subtype, got.frame_subtype);
        check_field("address_one", want.address_one, got.address_one);
        check_field("address_two", want.address_two, got.address_two);
        check_field("address_three", want.address_three, got.address_three);
        check_field("address_four", want.address_four, got.address_four);
        check_field("sequence_control", want.sequence_control, got.sequence_control);
        check_field("qos_control", want.qos_control, got.qos_control);
        check_field("ht_control", want.ht_control, got.ht_control);
      end
      headers_seen++;
    end
    if (byte_taken) absorb_byte(s_axis_tdata, s_axis_tlast);
  end

  // Byte driver: holds a byte until taken, idles in random bursts
  always @(negedge clk_i) begin
    rx_byte_t nxt;
    if (rst_ni && !(s_axis_tvalid && !byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic byte_t fc_low(logic [3:0] sub, kind_e kind, logic [1:0] ver);
    return {sub, kind, ver};
  endfunction

  task automatic push_frame(byte_t fc0, byte_t fc1, int unsigned len, bit rand_fill,
                            byte_t fill);
    rx_byte_t fb;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) fb.data = fc0;
      else if (i == 1) fb.data = fc1;
      else if (rand_fill) fb.data = byte_t'($urandom_range(0, 255));
      else fb.data = fill;
      fb.last = (i == len - 1);
      pending_bytes.push_back(fb);
    end
    frames_queued++;
    bytes_queued += len;
  endtask

  // Mostly well-formed frames around the length thresholds, plus broken ones
  task automatic push_random_frame();
    int unsigned pick;
    int unsigned base;
    int unsigned len;
    byte_t       fc1;
    logic [3:0]  sub;
    kind_e       kind;
    pick = $urandom_range(0, 99);
    fc1  = byte_t'($urandom_range(0, 255));
    sub  = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: kind = KindData;
      5, 6:          kind = KindMgmt;
      7, 8:          kind = KindCtrl;
      default:       kind = KindExt;
    endcase
    if (kind == KindCtrl && $urandom_range(0, 1) == 1) sub = SubRts + 4'($urandom_range(0, 2));
    if (kind == KindData && $urandom_range(0, 2) == 0) fc1[1:0] = 2'b11;
    if (kind == KindData && $urandom_range(0, 1) == 1) sub[3] = 1'b1;
    if (kind == KindData) base = (fc1[0] && fc1[1]) ? MinLen4Addr : MinLen3Addr;
    else if (kind == KindMgmt) base = MinLen3Addr;
    else base = MinLenAny;
    if (pick < 75) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(35, 70) : base + $urandom_range(0, 8);
      push_frame(fc_low(sub, kind, 2'b00), fc1, len, 1'b1, 8'h00);
    end else if (pick < 85) begin
      push_frame(fc_low(sub, kind, 2'b00), fc1, $urandom_range(1, base - 1), 1'b1, 8'h00);
    end else if (pick < 93) begin
      push_frame(fc_low(sub, kind, 2'($urandom_range(1, 3))), fc1, $urandom_range(1, 40),
                 1'b1, 8'h00);
    end else begin
      push_frame(byte_t'($urandom_range(0, 255)), fc1, $urandom_range(1, 70), 1'b1, 8'h00);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames: short, bad version, each kind at its length limits
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h00, 1, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindData, 2'd1), 8'h03, 9, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindMgmt, 2'd1), 8'h00, 10, 1'b1, 8'h00);
    push_frame(fc_low(4'hF, KindExt, 2'd3), 8'hFF, 24, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h01, 23, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h01, 24, 1'b1, 8'h00);
    push_frame(fc_low(4'h2, KindData, 2'd0), 8'h02, 24, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h03, 29, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h03, 30, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindData, 2'd0), 8'h80, 24, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindData, 2'd0), 8'h80, 26, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindData, 2'd0), 8'h80, 28, 1'b1, 8'h00);
    push_frame(fc_low(4'hC, KindData, 2'd0), 8'h83, 34, 1'b1, 8'h00);
    push_frame(fc_low(4'h0, KindData, 2'd0), 8'h80, 26, 1'b1, 8'h00);
    push_frame(fc_low(4'h4, KindMgmt, 2'd0), 8'h00, 23, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindMgmt, 2'd0), 8'h83, 30, 1'b1, 8'h00);
    push_frame(fc_low(SubRts, KindCtrl, 2'd0), 8'h00, 10, 1'b1, 8'h00);
    push_frame(fc_low(SubCts, KindCtrl, 2'd0), 8'h10, 10, 1'b1, 8'h00);
    push_frame(fc_low(SubAck, KindCtrl, 2'd0), 8'h00, 14, 1'b1, 8'h00);
    push_frame(fc_low(SubRts, KindCtrl, 2'd0), 8'h00, 9, 1'b1, 8'h00);
    push_frame(fc_low(4'h9, KindCtrl, 2'd0), 8'h00, 16, 1'b1, 8'h00);
    push_frame(fc_low(4'h6, KindExt, 2'd0), 8'hFF, 10, 1'b1, 8'h00);
    push_frame(fc_low(4'h8, KindData, 2'd0), 8'h81, 70, 1'b1, 8'h00);
    push_frame(fc_low(4'hF, KindData, 2'd0), 8'hFF, 34, 1'b0, 8'hFF);
    push_frame(8'h00, 8'h00, 24, 1'b0, 8'h00);

    // Let everything drain before the random traffic starts
    while (headers_seen < frames_queued) @(negedge clk_i);

    while (bytes_queued < 650) push_random_frame();

    // Final stretch runs at full rate on both sides
    while (pending_bytes.size() > 4) @(posedge clk_i);
    idle_on = 1'b0;
    repeat (6) push_random_frame();

    while (headers_seen < frames_queued) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_headers.size() != 0) error_count++;

    $display("%0d frames, %0d bytes decoded: %0d ok, %0d bad version, %0d too short",
             frames_queued, bytes_queued, status_tally[StOk], status_tally[StBadVersion],
             status_tally[StShort]);
    $display("%0d field mismatches or stray headers", error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d of %0d headers received", headers_seen, frames_queued);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
